// File: design/smau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smau_pkg
// Types, op codes and constants shared by the stack arithmetic unit.
// ----------------------------------------------------------------------------
package smau_pkg;

  localparam int unsigned DefStackDepth = 64;
  localparam int unsigned CellW = 64;
  localparam int unsigned OpW = 5;
  localparam int unsigned DepthW = 7;
  localparam int unsigned ErrW = 2;

  typedef enum logic [OpW-1:0] {
    OP_PUSH = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3,
    OP_DIV = 5'd4, OP_MOD = 5'd5, OP_DIVMOD = 5'd6, OP_MULDIV = 5'd7,
    OP_MULDIVMOD = 5'd8, OP_INC1 = 5'd9, OP_DEC1 = 5'd10, OP_INC2 = 5'd11,
    OP_DEC2 = 5'd12, OP_SHL = 5'd13, OP_SHR = 5'd14, OP_ABS = 5'd15,
    OP_NEG = 5'd16, OP_MIN = 5'd17, OP_MAX = 5'd18
  } op_t;

  typedef enum logic [ErrW-1:0] {
    ERR_OK = 2'd0, ERR_UNDER = 2'd1, ERR_DIVZ = 2'd2, ERR_OVER = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHK, ST_POP, ST_EXEC, ST_MULA, ST_MULB, ST_DSTART, ST_DIV,
    ST_WRA, ST_WRB, ST_RDT, ST_RDS, ST_RDL, ST_OUT
  } state_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic signed [CellW-1:0] literal;
  } in_word_t;

  typedef struct packed {
    logic signed [CellW-1:0] top_value;
    logic signed [CellW-1:0] second_value;
    logic [DepthW-1:0] depth;
    logic [ErrW-1:0] error_code;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic [127:0] dividend;
    logic [CellW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [CellW-1:0] quo;
    logic [CellW-1:0] rem;
  } div_rsp_t;

endpackage

// File: design/smau_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smau_div
// Unsigned 128 / 64 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smau_div import smau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [127:0] num;
  logic [CellW-1:0] rem;
  logic [CellW-1:0] quo;
  logic [CellW-1:0] dsr;
  logic [7:0] cnt;
  logic busy;
  logic done_r;

  logic [CellW:0] shifted;
  logic take;

  // one restoring step
  always_comb begin
    shifted = {rem, num[127]};
    take = (shifted >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        num <= req.dividend;
        dsr <= req.divisor;
        rem <= '0;
        quo <= '0;
        cnt <= 8'd128;
      end else if (busy) begin
        num <= {num[126:0], 1'b0};
        rem <= take ? CellW'(shifted - {1'b0, dsr}) : shifted[CellW-1:0];
        quo <= {quo[CellW-2:0], take};
        cnt <= cnt - 8'd1;
        if (cnt == 8'd1) begin
          busy <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo = quo;
  assign rsp.rem = rem;

endmodule

// File: design/stack_machine_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_arithmetic_unit_core
// Forth arithmetic words on a data stack held in a synchronous RAM.
// A word is checked, pops its operands and executes, then the top two cells are
// read back; push and faulted words go straight to the read-back. * adds a split
// multiply, the divide words run the bit-serial divider, star-slash both.
// One word in flight; the next is taken the cycle after the result leaves.
// Reset empties the stack at once; the RAM itself is not cleared.
// ----------------------------------------------------------------------------
module stack_machine_arithmetic_unit_core import smau_pkg::*; #(
  parameter int unsigned STACK_DEPTH = DefStackDepth
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  state_t state, state_next;

  logic [CellW-1:0] mem [STACK_DEPTH];
  logic [CellW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic rd_en;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [CellW-1:0] wr_data;

  logic [CW-1:0] count;
  logic [OpW-1:0] op;
  logic [CellW-1:0] lit;
  logic [1:0] need;
  logic [1:0] got;
  logic [ErrW-1:0] err;
  logic [CellW-1:0] t0, t1, t2;
  logic [CellW-1:0] res_a, res_b;
  logic [63:0] pll, plh, phl, phh;
  logic [127:0] prod;
  logic [127:0] prod_sum;
  logic [CellW-1:0] mul_a, mul_b;
  logic neg_n;
  logic [CellW-1:0] quo_s, rem_s;
  logic [CellW-1:0] alu;
  logic [CellW-1:0] top_r, sec_r;
  logic is_div2, is_star, is_mul, two_push, last_pop;

  div_req_t dreq;
  div_rsp_t drsp;

  smau_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  function automatic logic [1:0] need_of(input logic [OpW-1:0] o);
    logic [1:0] n;
    n = 2'd0;
    if (o >= OP_ADD && o <= OP_DIVMOD) n = 2'd2;
    else if (o == OP_MULDIV || o == OP_MULDIVMOD) n = 2'd3;
    else if (o >= OP_INC1 && o <= OP_NEG) n = 2'd1;
    else if (o == OP_MIN || o == OP_MAX) n = 2'd2;
    return n;
  endfunction

  function automatic logic [CellW-1:0] mag(input logic [CellW-1:0] v);
    return v[CellW-1] ? CellW'(-v) : v;
  endfunction

  assign is_div2 = (op == OP_DIV || op == OP_MOD || op == OP_DIVMOD);
  assign is_star = (op == OP_MULDIV || op == OP_MULDIVMOD);
  assign is_mul = (op == OP_MUL);
  assign two_push = (op == OP_DIVMOD || op == OP_MULDIVMOD);
  assign last_pop = ((got + 2'd1) == need);

  // stack RAM
  assign wr_addr = AW'(count);
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_CHK;
      ST_CHK: begin
        if (need == 2'd0 || count < CW'(need)) state_next = ST_RDT;
        else state_next = ST_POP;
      end
      ST_POP: if (last_pop) state_next = ST_EXEC;
      ST_EXEC: begin
        if (is_mul) state_next = ST_MULA;
        else if (is_star) state_next = (t0 == '0) ? ST_RDT : ST_MULA;
        else if (is_div2) state_next = (t0 == '0) ? ST_RDT : ST_DIV;
        else state_next = ST_RDT;
      end
      ST_MULA: state_next = ST_MULB;
      ST_MULB: state_next = is_mul ? ST_WRA : ST_DSTART;
      ST_DSTART: state_next = ST_DIV;
      ST_DIV: if (drsp.done) state_next = ST_WRA;
      ST_WRA: state_next = two_push ? ST_WRB : ST_RDT;
      ST_WRB: state_next = ST_RDT;
      ST_RDT: state_next = ST_RDS;
      ST_RDS: state_next = ST_RDL;
      ST_RDL: state_next = ST_OUT;
      ST_OUT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = (state != ST_IDLE);
    out_valid = (state == ST_OUT);
  end

  // unary and binary results; t0 is the old top, t1 the cell below
  always_comb begin
    case (op)
      OP_INC1: alu = t0 + 64'd1;
      OP_DEC1: alu = t0 - 64'd1;
      OP_INC2: alu = t0 + 64'd2;
      OP_DEC2: alu = t0 - 64'd2;
      OP_SHL: alu = {t0[CellW-2:0], 1'b0};
      OP_SHR: alu = {t0[CellW-1], t0[CellW-1:1]};
      OP_ABS: alu = mag(t0);
      OP_NEG: alu = CellW'(-t0);
      OP_ADD: alu = t1 + t0;
      OP_SUB: alu = t1 - t0;
      OP_MIN: alu = ($signed(t1) < $signed(t0)) ? t1 : t0;
      OP_MAX: alu = ($signed(t0) < $signed(t1)) ? t1 : t0;
      default: alu = t0;
    endcase
  end

  // split multiply operands and product assembly
  assign mul_a = is_star ? mag(t2) : t1;
  assign mul_b = is_star ? mag(t1) : t0;
  assign prod_sum = {64'd0, pll} + {32'd0, plh, 32'd0}
                  + {32'd0, phl, 32'd0} + {phh, 64'd0};

  // signed fix-up of the divider result
  assign neg_n = is_star ? (t2[CellW-1] ^ t1[CellW-1]) : t1[CellW-1];
  assign quo_s = (neg_n != t0[CellW-1]) ? CellW'(-drsp.quo) : drsp.quo;
  assign rem_s = neg_n ? CellW'(-drsp.rem) : drsp.rem;

  // divider request
  always_comb begin
    dreq.start = (state == ST_EXEC && is_div2 && t0 != '0) || (state == ST_DSTART);
    dreq.dividend = is_star ? prod : {64'd0, mag(t1)};
    dreq.divisor = mag(t0);
  end

  // RAM control
  always_comb begin
    rd_en = 1'b0;
    rd_addr = AW'(count - CW'(1));
    wr_en = 1'b0;
    wr_data = res_a;
    case (state)
      ST_CHK: begin
        if (op == OP_PUSH) begin
          wr_en = (count < CW'(STACK_DEPTH));
          wr_data = lit;
        end else if (need != 2'd0 && count >= CW'(need)) rd_en = 1'b1;
      end
      ST_POP: rd_en = !last_pop;
      ST_EXEC: begin
        wr_en = !is_mul && !is_star && !is_div2;
        wr_data = alu;
      end
      ST_WRA: wr_en = 1'b1;
      ST_WRB: begin
        wr_en = 1'b1;
        wr_data = res_b;
      end
      ST_RDT: rd_en = 1'b1;
      ST_RDS: begin
        rd_en = 1'b1;
        rd_addr = AW'(count - CW'(2));
      end
      default: ;
    endcase
  end

  // sequencer registers and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (in_valid) begin
          op <= in_data.op;
          lit <= in_data.literal;
          need <= need_of(in_data.op);
          got <= 2'd0;
          err <= ERR_OK;
        end
        ST_CHK: begin
          if (op == OP_PUSH) begin
            if (count < CW'(STACK_DEPTH)) count <= count + CW'(1);
            else err <= ERR_OVER;
          end else if (count < CW'(need)) err <= ERR_UNDER;
          else if (need != 2'd0) count <= count - CW'(1);
        end
        ST_POP: begin
          case (got)
            2'd0: t0 <= rd_data;
            2'd1: t1 <= rd_data;
            default: t2 <= rd_data;
          endcase
          got <= got + 2'd1;
          if (!last_pop) count <= count - CW'(1);
        end
        ST_EXEC: begin
          if ((is_star || is_div2) && t0 == '0) err <= ERR_DIVZ;
          else if (!is_mul && !is_star && !is_div2) count <= count + CW'(1);
        end
        ST_MULA: begin
          pll <= mul_a[31:0] * mul_b[31:0];
          plh <= mul_a[31:0] * mul_b[63:32];
          phl <= mul_a[63:32] * mul_b[31:0];
          phh <= mul_a[63:32] * mul_b[63:32];
        end
        ST_MULB: begin
          prod <= prod_sum;
          res_a <= prod_sum[CellW-1:0];
        end
        ST_DIV: if (drsp.done) begin
          res_a <= (two_push || op == OP_MOD) ? rem_s : quo_s;
          res_b <= quo_s;
        end
        ST_WRA: count <= count + CW'(1);
        ST_WRB: count <= count + CW'(1);
        ST_RDS: top_r <= (count >= CW'(1)) ? rd_data : '0;
        ST_RDL: sec_r <= (count >= CW'(2)) ? rd_data : '0;
        default: ;
      endcase
    end
  end

  assign out_data.top_value = top_r;
  assign out_data.second_value = sec_r;
  assign out_data.depth = DepthW'(count);
  assign out_data.error_code = err;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the stack arithmetic unit against a behavioral stack predictor.
// Drives directed and random op sequences through the valid/stall channels
// under several idle/stall phases and compares every result word in order.
// ----------------------------------------------------------------------------
module testbench;
  import smau_pkg::*;

  localparam int Depth = DefStackDepth;
  localparam int WatchLimit = 20000;
  localparam int HoldLen = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;

  stack_machine_arithmetic_unit_core u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [63:0] cells [Depth];
  int unsigned cell_cnt;

  in_word_t pending_words[$];
  out_word_t expected_words[$];
  int mismatches = 0;
  int results_seen = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // signed (neg ? -num : num) / d, truncating; num is 128-bit magnitude
  function automatic void sdiv(logic [127:0] num, bit neg, logic [63:0] d,
                               output logic [63:0] q, output logic [63:0] r);
    logic [127:0] uq;
    logic [127:0] ur;
    uq = num / {64'd0, mag(d)};
    ur = num % {64'd0, mag(d)};
    q = (neg != d[63]) ? -uq[63:0] : uq[63:0];
    r = neg ? -ur[63:0] : ur[63:0];
  endfunction

  function automatic void push_cell(logic [63:0] v);
    cells[cell_cnt % Depth] = v;
    cell_cnt++;
  endfunction

  function automatic logic [63:0] pop_cell();
    cell_cnt--;
    return cells[cell_cnt % Depth];
  endfunction

  // compute the result word for one accepted op
  function automatic out_word_t stack_step(in_word_t w);
    out_word_t res;
    int need;
    logic [1:0] err;
    logic [63:0] a, b, c, q, r;
    op_t op;
    need = 0;
    err = ERR_OK;
    op = op_t'(w.op);
    if (w.op >= OP_ADD && w.op <= OP_DIVMOD) need = 2;
    else if (w.op == OP_MULDIV || w.op == OP_MULDIVMOD) need = 3;
    else if (w.op >= OP_INC1 && w.op <= OP_NEG) need = 1;
    else if (w.op == OP_MIN || w.op == OP_MAX) need = 2;
    if (w.op == OP_PUSH) begin
      if (cell_cnt >= Depth) err = ERR_OVER;
      else push_cell(w.literal);
    end else if (w.op > OP_MAX) begin
      err = ERR_OK;
    end else if (cell_cnt < need) begin
      err = ERR_UNDER;
    end else if (need == 1) begin
      a = pop_cell();
      case (op)
        OP_INC1: a = a + 1;
        OP_DEC1: a = a - 1;
        OP_INC2: a = a + 2;
        OP_DEC2: a = a - 2;
        OP_SHL: a = a << 1;
        OP_SHR: a = {a[63], a[63:1]};
        OP_ABS: a = mag(a);
        default: a = -a;
      endcase
      push_cell(a);
    end else if (need == 2) begin
      b = pop_cell();
      a = pop_cell();
      if (op == OP_DIV || op == OP_MOD || op == OP_DIVMOD) begin
        if (b == 0) err = ERR_DIVZ;
        else begin
          sdiv({64'd0, mag(a)}, a[63], b, q, r);
          if (op == OP_DIV) push_cell(q);
          else if (op == OP_MOD) push_cell(r);
          else begin
            push_cell(r);
            push_cell(q);
          end
        end
      end else begin
        case (op)
          OP_ADD: a = a + b;
          OP_SUB: a = a - b;
          OP_MUL: a = a * b;
          OP_MIN: a = ($signed(a) < $signed(b)) ? a : b;
          default: a = ($signed(b) < $signed(a)) ? a : b;
        endcase
        push_cell(a);
      end
    end else begin
      c = pop_cell();
      b = pop_cell();
      a = pop_cell();
      if (c == 0) err = ERR_DIVZ;
      else begin
        sdiv({64'd0, mag(a)} * {64'd0, mag(b)}, a[63] ^ b[63], c, q, r);
        if (op == OP_MULDIVMOD) push_cell(r);
        push_cell(q);
      end
    end
    res.top_value = (cell_cnt >= 1) ? cells[(cell_cnt - 1) % Depth] : '0;
    res.second_value = (cell_cnt >= 2) ? cells[(cell_cnt - 2) % Depth] : '0;
    res.depth = cell_cnt[DepthW-1:0];
    res.error_code = err;
    return res;
  endfunction

  function automatic logic [63:0] rand_cell();
    case ($urandom_range(0, 7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return '0;
      3: return -64'sd1;
      4: return 64'($signed($urandom_range(0, 20)) - 10);
      5: return {32'($urandom()), 32'($urandom())} >> $urandom_range(0, 63);
      default: return {32'($urandom()), 32'($urandom())};
    endcase
  endfunction

  function automatic in_word_t mk(logic [OpW-1:0] op, logic [63:0] lit);
    in_word_t w;
    w.op = op;
    w.literal = lit;
    return w;
  endfunction

  // driver: pop a word when the current one is taken or none is offered
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one counted long hold-off when requested
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      if (hold_cnt >= HoldLen - 1) hold_done <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor: predict on input accept, check on output accept
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) expected_words.push_back(stack_step(in_data));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %p", out_data);
        end else begin
          out_word_t exp_w;
          exp_w = expected_words.pop_front();
          if (exp_w !== out_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", exp_w, out_data);
          end
        end
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst
        || (pending_words.size() == 0 && expected_words.size() == 0 && !in_valid))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
  endtask

  // random sequences: pushes, ops and undefined op codes, mixed at random
  task automatic random_part(int n);
    int k;
    for (k = 0; k < n; k++) begin
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 40) pending_words.push_back(mk(OP_PUSH, rand_cell()));
      else if (sel < 97)
        pending_words.push_back(mk(OpW'($urandom_range(1, 18)), rand_cell()));
      else pending_words.push_back(mk(OpW'($urandom_range(19, 31)), rand_cell()));
    end
  endtask

  initial begin
    int i;
    int ph;
    cell_cnt = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: underflow on empty, extremes, every unary op, divide by zero
    pending_words.push_back(mk(OP_ADD, '1));
    pending_words.push_back(mk(OP_ABS, '0));
    pending_words.push_back(mk(OP_MULDIV, '0));
    pending_words.push_back(mk(OP_PUSH, 64'h8000_0000_0000_0000));
    pending_words.push_back(mk(OP_PUSH, -64'sd1));
    pending_words.push_back(mk(OP_DIVMOD, '0));
    pending_words.push_back(mk(OP_PUSH, 64'h7fff_ffff_ffff_ffff));
    pending_words.push_back(mk(OP_PUSH, 64'h7fff_ffff_ffff_ffff));
    pending_words.push_back(mk(OP_PUSH, 64'd3));
    pending_words.push_back(mk(OP_MULDIVMOD, '0));
    pending_words.push_back(mk(OP_PUSH, '0));
    pending_words.push_back(mk(OP_MOD, '0));
    for (i = OP_INC1; i <= OP_NEG; i++) pending_words.push_back(mk(OpW'(i), '0));
    pending_words.push_back(mk(OP_PUSH, -64'sd7));
    pending_words.push_back(mk(OP_MIN, '0));
    pending_words.push_back(mk(5'd31, '1));
    drain();

    // fill past full for overflow, then empty with arithmetic
    for (i = 0; i < Depth + 2; i++) pending_words.push_back(mk(OP_PUSH, rand_cell()));
    for (i = 0; i < Depth + 2; i++) pending_words.push_back(mk(OP_MAX, '0));
    for (i = 0; i < 20; i++) pending_words.push_back(mk(OP_MUL, '0));
    drain();

    // random phases with differing idle/stall mixes
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 60; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 60; end
        3: begin idle_pct = 28; stall_pct = 28; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      if (ph == 4) hold_req = 1'b1;
      random_part(200);
      drain();
    end
    idle_pct = 0;
    stall_pct = 0;
    repeat (300) @(posedge clk);
    $display("ran directed edge cases plus ~1000 random ops; %0d results checked",
             results_seen);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// File: sim.f
design/smau_pkg.sv
design/smau_div.sv
design/stack_machine_arithmetic_unit_core.sv
test/testbench.sv
